// File: rtl/periodic_task_timer_table_core_assert.svh
// Assertion macros used by the timer table RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef PERIODIC_TASK_TIMER_TABLE_CORE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define PTT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer table check failed");

// Next-cycle implication.
`define PTT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer table check failed");

`endif

// File: rtl/ptt_pkg.sv
package ptt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int TIME_WIDTH  = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TICK    = 2'd1,
        OP_CONTROL = 2'd2,
        OP_PROCESS = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK      = 2'd0,
        KIND_DISPATCH = 2'd1,
        KIND_NONE     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [15:0]           id;
        logic [TIME_WIDTH-1:0] period;
        logic [TIME_WIDTH-1:0] countdown;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } ram_req_t;

endpackage

// File: rtl/ptt_ram.sv
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ptt_engine.sv
`include "periodic_task_timer_table_core_assert.svh"

module ptt_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [4:0]            active_entries,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [3:0]            entry_index,
    input  logic [15:0]           entry_id,
    input  logic [15:0]           period,
    input  logic                  enable,
    input  logic                  has_handler,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            kind,
    output logic [3:0]            slot,
    output logic [15:0]           task_id,
    output logic                  last,
    output ptt_pkg::ram_req_t     ram_req,
    input  logic [ptt_pkg::ENTRY_W-1:0] ram_rd_data
);

    import ptt_pkg::*;

    state_t                  state_reg;
    state_t                  state_next;
    op_t                     op_reg;
    logic [15:0]             tid_reg;
    logic                    en_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        rd_cnt_reg;
    logic                    s1_valid_reg;
    logic [IDX_W-1:0]        s1_idx_reg;
    logic [MAX_ENTRIES-1:0]  enabled_reg;
    logic [MAX_ENTRIES-1:0]  ready_reg;
    logic [MAX_ENTRIES-1:0]  handler_reg;
    logic [MAX_ENTRIES-1:0]  cd_valid_reg;
    logic                    pend_valid_reg;
    logic [3:0]              pend_slot_reg;
    logic [15:0]             pend_id_reg;
    logic                    out_valid_reg;
    kind_t                   out_kind_reg;
    logic [3:0]              out_slot_reg;
    logic [15:0]             out_id_reg;
    logic                    out_last_reg;

    op_t                     in_op;
    logic                    accept;
    logic                    load_write;
    logic                    out_free;
    entry_t                  ent;
    logic                    hit_dispatch;
    logic                    need_push;
    logic                    s1_go;
    logic                    issue;
    logic                    sweep_done;
    logic                    finish_go;
    logic [CNT_W-1:0]        n_in;
    logic                    tick_write;
    logic [TIME_WIDTH-1:0]   cd_cur;
    logic                    cd_expired;
    logic [TIME_WIDTH-1:0]   cd_new;

    assign in_op      = op_t'(operation);
    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign in_stall   = (state_reg != ST_IDLE);
    assign load_write = accept && (in_op == OP_LOAD) && (32'(entry_index) < MAX_ENTRIES);
    assign out_free   = !out_valid_reg || !out_stall;
    assign ent        = entry_t'(ram_rd_data);

    assign n_in = (32'(active_entries) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                       : CNT_W'(active_entries);

    assign hit_dispatch = s1_valid_reg && (op_reg == OP_PROCESS)
                          && ready_reg[s1_idx_reg] && handler_reg[s1_idx_reg];
    assign need_push    = hit_dispatch && pend_valid_reg;
    assign s1_go        = s1_valid_reg && (!need_push || out_free);
    assign issue        = (state_reg == ST_SWEEP) && (rd_cnt_reg < n_reg)
                          && (!s1_valid_reg || s1_go);
    assign sweep_done   = (state_reg == ST_SWEEP) && (rd_cnt_reg == n_reg)
                          && (!s1_valid_reg || s1_go);
    assign finish_go    = (state_reg == ST_FINISH) && out_free;

    assign cd_cur     = cd_valid_reg[s1_idx_reg] ? ent.countdown : '0;
    assign cd_expired = (cd_cur <= TIME_WIDTH'(1));
    assign cd_new     = (cd_expired ? ent.period : cd_cur) - TIME_WIDTH'(1);
    assign tick_write = s1_go && (op_reg == OP_TICK) && enabled_reg[s1_idx_reg];

    always_comb
    begin
        ram_req = '0;
        ram_req.rd_en   = issue;
        ram_req.rd_addr = rd_cnt_reg[IDX_W-1:0];
        if (load_write)
        begin
            ram_req.wr_en             = 1'b1;
            ram_req.wr_addr           = IDX_W'(entry_index);
            ram_req.wr_data.id        = entry_id;
            ram_req.wr_data.period    = TIME_WIDTH'(period);
            ram_req.wr_data.countdown = '0;
        end
        else if (tick_write)
        begin
            ram_req.wr_en             = 1'b1;
            ram_req.wr_addr           = s1_idx_reg;
            ram_req.wr_data.id        = ent.id;
            ram_req.wr_data.period    = ent.period;
            ram_req.wr_data.countdown = cd_new;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((in_op == OP_LOAD) || (n_in == '0))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= OP_LOAD;
            tid_reg        <= '0;
            en_reg         <= 1'b0;
            n_reg          <= '0;
            rd_cnt_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            s1_idx_reg     <= '0;
            enabled_reg    <= '0;
            ready_reg      <= '0;
            handler_reg    <= '0;
            cd_valid_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                op_reg     <= in_op;
                tid_reg    <= entry_id;
                en_reg     <= enable;
                n_reg      <= n_in;
                rd_cnt_reg <= '0;
            end
            if (load_write)
            begin
                enabled_reg[IDX_W'(entry_index)]  <= enable;
                handler_reg[IDX_W'(entry_index)]  <= has_handler;
                ready_reg[IDX_W'(entry_index)]    <= 1'b0;
                cd_valid_reg[IDX_W'(entry_index)] <= 1'b1;
            end

            if (issue)
            begin
                rd_cnt_reg   <= rd_cnt_reg + CNT_W'(1);
                s1_idx_reg   <= rd_cnt_reg[IDX_W-1:0];
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (tick_write)
            begin
                cd_valid_reg[s1_idx_reg] <= 1'b1;
                if (cd_expired)
                begin
                    ready_reg[s1_idx_reg] <= 1'b1;
                end
            end
            if (s1_go && (op_reg == OP_CONTROL) && (ent.id == tid_reg))
            begin
                enabled_reg[s1_idx_reg] <= en_reg;
            end
            if (s1_go && (op_reg == OP_PROCESS))
            begin
                ready_reg[s1_idx_reg] <= 1'b0;
            end

            if (s1_go && hit_dispatch)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (finish_go)
            begin
                pend_valid_reg <= 1'b0;
            end

            if ((s1_go && need_push) || finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && hit_dispatch)
        begin
            pend_slot_reg <= 4'(s1_idx_reg);
            pend_id_reg   <= ent.id;
        end
        if (s1_go && need_push)
        begin
            out_kind_reg <= KIND_DISPATCH;
            out_slot_reg <= pend_slot_reg;
            out_id_reg   <= pend_id_reg;
            out_last_reg <= 1'b0;
        end
        else if (finish_go)
        begin
            out_last_reg <= 1'b1;
            if ((op_reg == OP_PROCESS) && pend_valid_reg)
            begin
                out_kind_reg <= KIND_DISPATCH;
                out_slot_reg <= pend_slot_reg;
                out_id_reg   <= pend_id_reg;
            end
            else
            begin
                out_kind_reg <= (op_reg == OP_PROCESS) ? KIND_NONE : KIND_ACK;
                out_slot_reg <= '0;
                out_id_reg   <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign slot      = out_slot_reg;
    assign task_id   = out_id_reg;
    assign last      = out_last_reg;

    `PTT_ASSERT_IMP(a_no_rw_same_entry, ram_req.wr_en && ram_req.rd_en, ram_req.wr_addr != ram_req.rd_addr)
    `PTT_ASSERT_IMP(a_pend_only_process, pend_valid_reg, op_reg == OP_PROCESS)
    `PTT_ASSERT_IMP(a_s1_only_in_sweep, s1_valid_reg, state_reg == ST_SWEEP)
    `PTT_ASSERT_NXT(a_accept_blocks_next, in_valid && !in_stall, in_stall)

endmodule

// File: rtl/periodic_task_timer_table_core.sv
// Periodic task timer table.
// Commands enter on the input channel (in_valid, in_stall, payload ports) and
// results leave on the output channel (out_valid, out_stall, payload ports).
// A transfer happens at a rising edge where valid is high and stall is low.
// Load writes one table slot and offers one acknowledge from the finish state.
// Tick, control and process sweep the N entries in use through the entry
// memory, one read per cycle while the sweep does not stall, then offer the
// final result; N is set by the active_entries register (byte address 0 of the
// APB port). Process gives one dispatch result per ready entry with a handler,
// with last on the final one, or one nothing-ready result.
// Only one command is worked on at a time; the next one is taken in the cycle
// after the final result has moved into the output register, even if it is
// still waiting. When the receiver stalls, the output register holds its
// result and a process sweep pauses until the register frees up. Reset
// clears the register, the marks and all countdowns; ids and periods are
// undefined until loaded. No clearing pass is needed after reset.
module periodic_task_timer_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [3:0]  entry_index,
    input  logic [15:0] entry_id,
    input  logic [15:0] period,
    input  logic        enable,
    input  logic        has_handler,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [3:0]  slot,
    output logic [15:0] task_id,
    output logic        last
);

    import ptt_pkg::*;

    logic [4:0]         active_reg;
    logic               cfg_write;
    ram_req_t           ram_req;
    logic [ENTRY_W-1:0] ram_rd_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (cfg_write)
        begin
            active_reg <= pwdata[4:0];
        end
    end

    assign prdata = {27'd0, active_reg};

    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    ptt_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .active_entries (active_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .entry_index    (entry_index),
        .entry_id       (entry_id),
        .period         (period),
        .enable         (enable),
        .has_handler    (has_handler),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .slot           (slot),
        .task_id        (task_id),
        .last           (last),
        .ram_req        (ram_req),
        .ram_rd_data    (ram_rd_data)
    );

endmodule

// File: tb/tb_periodic_task_timer_table_core.sv
module tb_periodic_task_timer_table_core;
    import ptt_pkg::*;

    localparam logic [1:0] ADDR_ACTIVE_ENTRIES = 2'd0;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 81;
    localparam logic [15:0] ID_POOL [5] = '{16'h0000, 16'hffff, 16'h0101, 16'h0102, 16'h0103};

    typedef struct packed {
        op_t         op;
        logic [3:0]  idx;
        logic [15:0] id;
        logic [15:0] per;
        logic        en;
        logic        hh;
    } table_cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slot;
        logic [15:0] task_id;
        logic        last;
    } table_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = ADDR_ACTIVE_ENTRIES;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [3:0]  entry_index = '0;
    logic [15:0] entry_id = '0;
    logic [15:0] period = '0;
    logic        enable = 1'b0;
    logic        has_handler = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] task_id;
    logic        last;

    bit [15:0]           slot_id [MAX_ENTRIES];
    bit [TIME_WIDTH-1:0] slot_period [MAX_ENTRIES];
    bit [TIME_WIDTH-1:0] slot_countdown [MAX_ENTRIES];
    bit                  slot_enabled [MAX_ENTRIES];
    bit                  slot_ready [MAX_ENTRIES];
    bit                  slot_handler [MAX_ENTRIES];
    logic [4:0]          active_cfg = '0;

    table_cmd_t  cmd_backlog [$];
    table_resp_t responses_due [$];
    table_cmd_t  current_cmd;
    table_cmd_t  next_cmd;
    table_resp_t oldest_due;
    bit          no_idle = 1'b0;
    int          mismatch_count = 0;
    int          cycles_since_transfer = 0;

    periodic_task_timer_table_core i_dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic table_cmd_t make_cmd(op_t op, logic [3:0] idx, logic [15:0] id,
                                            logic [15:0] per, logic en, logic hh);
        return '{op, idx, id, per, en, hh};
    endfunction

    function automatic table_cmd_t random_cmd();
        table_cmd_t c;
        int pick;
        pick = $urandom_range(99);
        c.op = (pick < 20) ? OP_LOAD : (pick < 55) ? OP_TICK :
               (pick < 70) ? OP_CONTROL : OP_PROCESS;
        c.idx = 4'($urandom_range(15));
        c.id = ($urandom_range(3) == 0) ? 16'($urandom) : ID_POOL[$urandom_range(4)];
        c.per = ($urandom_range(9) < 7) ? 16'($urandom_range(6)) : 16'($urandom);
        c.en = ($urandom_range(9) < 8);
        c.hh = ($urandom_range(9) < 7);
        return c;
    endfunction

    function automatic void advance_timer_table(table_cmd_t c);
        table_resp_t batch [$];
        int in_use;
        in_use = (active_cfg > MAX_ENTRIES) ? MAX_ENTRIES : int'(active_cfg);
        case (c.op)
            OP_LOAD:
            begin
                slot_id[c.idx] = c.id;
                slot_period[c.idx] = c.per;
                slot_handler[c.idx] = c.hh;
                slot_enabled[c.idx] = c.en;
                slot_countdown[c.idx] = '0;
                slot_ready[c.idx] = 1'b0;
            end
            OP_TICK:
            begin
                for (int i = 0; i < in_use; i++)
                begin
                    if (slot_enabled[i])
                    begin
                        if (slot_countdown[i] <= 1)
                        begin
                            slot_ready[i] = 1'b1;
                            slot_countdown[i] = slot_period[i];
                        end
                        slot_countdown[i] = slot_countdown[i] - 1'b1;
                    end
                end
            end
            OP_CONTROL:
            begin
                for (int i = 0; i < in_use; i++)
                    if (slot_id[i] == c.id)
                        slot_enabled[i] = c.en;
            end
            default:
            begin
                for (int i = 0; i < in_use; i++)
                begin
                    if (slot_ready[i])
                    begin
                        slot_ready[i] = 1'b0;
                        if (slot_handler[i])
                            batch.push_back('{KIND_DISPATCH, 4'(i), slot_id[i], 1'b0});
                    end
                end
            end
        endcase
        if (c.op != OP_PROCESS)
            batch.push_back('{KIND_ACK, 4'd0, 16'd0, 1'b1});
        else if (batch.size() == 0)
            batch.push_back('{KIND_NONE, 4'd0, 16'd0, 1'b1});
        else
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            responses_due.push_back(batch[k]);
    endfunction

    // Command channel: hold a stalled transfer, otherwise offer the next command.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                advance_timer_table(current_cmd);
            if (!in_valid || !in_stall)
            begin
                if (cmd_backlog.size() != 0 && (no_idle || $urandom_range(99) >= 6))
                begin
                    next_cmd = cmd_backlog.pop_front();
                    current_cmd <= next_cmd;
                    in_valid <= 1'b1;
                    operation <= next_cmd.op;
                    entry_index <= next_cmd.idx;
                    entry_id <= next_cmd.id;
                    period <= next_cmd.per;
                    enable <= next_cmd.en;
                    has_handler <= next_cmd.hh;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= !no_idle && ($urandom_range(99) < 6);
            if (out_valid && !out_stall)
            begin
                if (responses_due.size() == 0)
                begin
                    $error("unexpected transfer: kind %0d slot %0d task_id %0h",
                           kind, slot, task_id);
                    mismatch_count++;
                end
                else
                begin
                    oldest_due = responses_due.pop_front();
                    if (kind !== oldest_due.kind)
                    begin
                        $error("kind: expected %0d, got %0d", oldest_due.kind, kind);
                        mismatch_count++;
                    end
                    if (slot !== oldest_due.slot)
                    begin
                        $error("slot: expected %0d, got %0d", oldest_due.slot, slot);
                        mismatch_count++;
                    end
                    if (task_id !== oldest_due.task_id)
                    begin
                        $error("task_id: expected %0h, got %0h", oldest_due.task_id, task_id);
                        mismatch_count++;
                    end
                    if (last !== oldest_due.last)
                    begin
                        $error("last: expected %0d, got %0d", oldest_due.last, last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                cycles_since_transfer <= 0;
            end
            else if (cycles_since_transfer == STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
            begin
                cycles_since_transfer <= cycles_since_transfer + 1;
            end
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || in_valid || responses_due.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_active_entries(input logic [4:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ACTIVE_ENTRIES;
        pwdata <= {27'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        active_cfg = value;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== {27'd0, value})
        begin
            $error("active_entries: expected %0d, got %0d", value, prdata);
            mismatch_count++;
        end
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [4:0] phase_cfg [5];
        phase_cfg = '{5'd31, 5'($urandom_range(2, 15)), 5'd1, 5'd16, 5'($urandom_range(3, 12))};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        write_active_entries(5'd0);

        // With no entries in use every sweep is empty; then fill the whole table.
        cmd_backlog.push_back(make_cmd(OP_TICK, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        cmd_backlog.push_back(make_cmd(OP_CONTROL, 4'd0, 16'h0000, 16'd0, 1'b1, 1'b0));
        cmd_backlog.push_back(make_cmd(OP_PROCESS, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        for (int i = 0; i < MAX_ENTRIES; i++)
            cmd_backlog.push_back(make_cmd(OP_LOAD, 4'(i), ID_POOL[i % 5],
                                           (i == 0) ? 16'h0000 : (i == 1) ? 16'hffff :
                                           16'((i % 4) + 1),
                                           (i % 3 != 2), (i % 4 != 1)));
        wait_drained();

        write_active_entries(5'd16);
        cmd_backlog.push_back(make_cmd(OP_TICK, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        cmd_backlog.push_back(make_cmd(OP_PROCESS, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        cmd_backlog.push_back(make_cmd(OP_CONTROL, 4'd0, 16'h0101, 16'd0, 1'b0, 1'b0));
        cmd_backlog.push_back(make_cmd(OP_TICK, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        cmd_backlog.push_back(make_cmd(OP_TICK, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        cmd_backlog.push_back(make_cmd(OP_PROCESS, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            write_active_entries(phase_cfg[p]);
            no_idle = (p == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 1 && k == PHASE_ITEMS / 2)
                    wait_drained();
                cmd_backlog.push_back(random_cmd());
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
